@@ design/rfe_pkg.sv @@
package rfe_pkg;

	localparam int COORD_W = 14;

	localparam logic [2:0] CMD_POINT   = 3'd0;
	localparam logic [2:0] CMD_HLINE   = 3'd1;
	localparam logic [2:0] CMD_VLINE   = 3'd2;
	localparam logic [2:0] CMD_OUTLINE = 3'd3;
	localparam logic [2:0] CMD_FILL    = 3'd4;
	localparam logic [2:0] CMD_READ    = 3'd5;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	// one command beat, lowest field last
	typedef struct packed {
		logic [2:0]  pad;
		logic [23:0] rgb_color;
		logic [9:0]  run_length;
		logic [9:0]  y_end;
		logic [9:0]  x_end;
		logic [9:0]  y_start;
		logic [9:0]  x_start;
		logic [2:0]  cmd;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pixels_written;
		logic [15:0] read_pixel;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_ADDR,
		ST_WALK,
		ST_NEXT,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic addr;
		logic walk;
		logic nxt_seg;
		logic rd;
		logic clear_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic nop;
		logic is_read;
		logic seg_empty;
		logic walk_last;
		logic more;
		logic clear_last;
	} ctrl_status_t;

endpackage

@@ design/rfe_datapath.sv @@
module rfe_datapath #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rfe_pkg::in_item_t                  in_item,
	input  logic [$clog2(MAX_COLUMNS+1)-1:0]   eff_cols,
	input  logic [$clog2(MAX_ROWS+1)-1:0]      eff_rows,
	input  rfe_pkg::ctrl_cmd_t                 cmd,
	output rfe_pkg::ctrl_status_t              status,
	output rfe_pkg::out_item_t                 out_item
);

	localparam int CW    = rfe_pkg::COORD_W;
	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int HW    = $clog2(MAX_COLUMNS + 1);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CLW   = $clog2(MAX_COLUMNS);
	localparam int MAXD  = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
	localparam int CNTW  = $clog2(MAXD + 1);
	localparam int PW    = RW + HW;
	localparam logic signed [CW-1:0] ONE  = CW'(1);
	localparam logic signed [CW-1:0] ZERO = CW'(0);

	logic [15:0]          mem_q [DEPTH];
	rfe_pkg::in_item_t    item_q;
	logic [1:0]           seg_idx_q;
	logic signed [CW-1:0] fill_x_q;
	logic [RW-1:0]        seg_x_q;
	logic [CLW-1:0]       seg_y_q;
	logic [CNTW-1:0]      seg_cnt_q;
	logic                 seg_horiz_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        clr_addr_q;
	logic [15:0]          wcount_q;
	logic [15:0]          rd_q;
	rfe_pkg::out_item_t   out_q;

	logic [15:0]          px565;
	logic signed [CW-1:0] wm1, hm1, xs_v, ys_v, xe_v, ye_v, len_v, xec, yec;
	logic signed [CW-1:0] rx, ry, rl, xc, yc, room, cnt_v;
	logic                 hz;
	logic [RW-1:0]        xdiff;
	logic [PW-1:0]        prod;
	logic [AW-1:0]        wr_addr;
	logic [15:0]          wr_data;

	assign px565 = {item_q.rgb_color[23:19], item_q.rgb_color[15:10], item_q.rgb_color[7:3]};

	assign wm1  = $signed(CW'(eff_rows)) - ONE;
	assign hm1  = $signed(CW'(eff_cols)) - ONE;
	assign xs_v = $signed(CW'(item_q.x_start));
	assign ys_v = $signed(CW'(item_q.y_start));
	assign xe_v = $signed(CW'(item_q.x_end));
	assign ye_v = $signed(CW'(item_q.y_end));
	assign len_v = $signed(CW'(item_q.run_length));
	assign xec  = (xe_v > wm1) ? wm1 : xe_v;
	assign yec  = (ye_v > hm1) ? hm1 : ye_v;

	// raw segment for the current command and side
	always_comb begin
		rx = xs_v;
		ry = ys_v;
		hz = 1'b1;
		rl = ZERO;
		case (item_q.cmd)
			rfe_pkg::CMD_POINT: begin
				rl = ONE;
			end
			rfe_pkg::CMD_HLINE: begin
				rl = len_v;
			end
			rfe_pkg::CMD_VLINE: begin
				hz = 1'b0;
				rl = len_v;
			end
			rfe_pkg::CMD_OUTLINE: begin
				case (seg_idx_q)
					2'd0: begin
						rl = xe_v - xs_v + ONE;
					end
					2'd1: begin
						ry = ye_v;
						rl = xe_v - xs_v + ONE;
					end
					2'd2: begin
						ry = ys_v + ONE;
						hz = 1'b0;
						rl = ye_v - ys_v - ONE;
					end
					default: begin
						rx = xe_v;
						ry = ys_v + ONE;
						hz = 1'b0;
						rl = ye_v - ys_v - ONE;
					end
				endcase
			end
			rfe_pkg::CMD_FILL: begin
				// fill runs as one vertical segment per column
				rx = fill_x_q;
				hz = 1'b0;
				rl = (fill_x_q > xec) ? ZERO : (yec - ys_v + ONE);
			end
			default: begin
				rl = ZERO;
			end
		endcase
	end

	assign xc    = (rx > wm1) ? wm1 : rx;
	assign yc    = (ry > hm1) ? hm1 : ry;
	assign room  = hz ? (wm1 - xc + ONE) : (hm1 - yc + ONE);
	assign cnt_v = (rl <= ZERO) ? ZERO : ((rl < room) ? rl : room);

	assign xdiff = RW'(wm1) - seg_x_q;
	assign prod  = PW'(xdiff) * PW'(eff_cols);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q    <= in_item;
			seg_idx_q <= 2'd0;
			fill_x_q  <= $signed(CW'(in_item.x_start));
			wcount_q  <= 16'd0;
		end
		if (cmd.setup) begin
			seg_x_q     <= RW'(xc);
			seg_y_q     <= CLW'(yc);
			seg_cnt_q   <= CNTW'(cnt_v);
			seg_horiz_q <= hz;
		end
		if (cmd.addr) begin
			addr_q <= AW'(prod + PW'(seg_y_q));
		end
		if (cmd.walk) begin
			addr_q    <= seg_horiz_q ? (addr_q - AW'(eff_cols)) : (addr_q + AW'(1));
			seg_cnt_q <= seg_cnt_q - CNTW'(1);
			wcount_q  <= wcount_q + 16'd1;
		end
		if (cmd.nxt_seg) begin
			seg_idx_q <= seg_idx_q + 2'd1;
			fill_x_q  <= fill_x_q + ONE;
		end
		if (cmd.out_load) begin
			out_q.read_pixel     <= rd_q;
			out_q.pixels_written <= wcount_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	assign wr_addr = cmd.clear_step ? clr_addr_q : addr_q;
	assign wr_data = cmd.clear_step ? 16'd0 : px565;

	always_ff @(posedge clk) begin
		if (cmd.clear_step || cmd.walk) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= 16'd0;
		end else if (cmd.rd) begin
			rd_q <= mem_q[addr_q];
		end
	end

	always_comb begin
		status.nop        = 1'b0;
		status.is_read    = (item_q.cmd == rfe_pkg::CMD_READ);
		status.seg_empty  = (seg_cnt_q == '0);
		status.walk_last  = (seg_cnt_q == CNTW'(1));
		status.clear_last = (clr_addr_q == AW'(DEPTH - 1));
		status.more       = 1'b0;
		case (item_q.cmd) inside
			rfe_pkg::CMD_POINT, rfe_pkg::CMD_HLINE, rfe_pkg::CMD_VLINE,
			rfe_pkg::CMD_READ: begin
				status.more = 1'b0;
			end
			rfe_pkg::CMD_OUTLINE: begin
				status.more = (seg_idx_q != 2'd3);
			end
			rfe_pkg::CMD_FILL: begin
				status.more = ((fill_x_q + ONE) <= xec);
			end
			default: begin
				status.nop = 1'b1;
			end
		endcase
	end

	assign out_item = out_q;

endmodule

@@ design/rfe_ctrl.sv @@
module rfe_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  rfe_pkg::ctrl_status_t status,
	output rfe_pkg::ctrl_cmd_t    cmd
);

	rfe_pkg::state_t state_q, state_nxt;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rfe_pkg::ST_CLEAR: if (status.clear_last) state_nxt = rfe_pkg::ST_IDLE;
			rfe_pkg::ST_IDLE:  if (in_valid) state_nxt = rfe_pkg::ST_SETUP;
			rfe_pkg::ST_SETUP: state_nxt = status.nop ? rfe_pkg::ST_DONE : rfe_pkg::ST_ADDR;
			rfe_pkg::ST_ADDR: begin
				if (status.is_read) state_nxt = rfe_pkg::ST_READ;
				else if (status.seg_empty) state_nxt = rfe_pkg::ST_NEXT;
				else state_nxt = rfe_pkg::ST_WALK;
			end
			rfe_pkg::ST_WALK:  if (status.walk_last) state_nxt = rfe_pkg::ST_NEXT;
			rfe_pkg::ST_NEXT:  state_nxt = status.more ? rfe_pkg::ST_SETUP : rfe_pkg::ST_DONE;
			rfe_pkg::ST_READ:  state_nxt = rfe_pkg::ST_DONE;
			rfe_pkg::ST_DONE:  if (out_free) state_nxt = rfe_pkg::ST_IDLE;
			default:           state_nxt = rfe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rfe_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			rfe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			rfe_pkg::ST_SETUP: cmd.setup = 1'b1;
			rfe_pkg::ST_ADDR:  cmd.addr = 1'b1;
			rfe_pkg::ST_WALK:  cmd.walk = 1'b1;
			rfe_pkg::ST_NEXT:  cmd.nxt_seg = 1'b1;
			rfe_pkg::ST_READ:  cmd.rd = 1'b1;
			rfe_pkg::ST_DONE:  cmd.out_load = out_free;
			default:           cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rfe_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/rotated_framebuffer_fill_engine.sv @@
// channel   dir  signals                     beat content
// s_axis    in   s_tvalid s_tready s_tdata   one drawing or read command
// m_axis    out  m_tvalid m_tready m_tdata   read pixel and write count
// cfg       in   cfg_we cfg_index cfg_data   panel_columns (0), panel_rows (1)
//
// one store write per cycle; a segment steps through setup, address multiply, its
// pixel writes and next, and a command adds accept and result; outline has four
// segments, fill one per column. read runs accept, setup, address, read, result.
// after reset the store is zeroed one word a cycle, all MAX_COLUMNS * MAX_ROWS words,
// with s_tready low; cfg writes are taken meanwhile. a result waits in an output
// register, so a command only stalls at its end while that register is still full.
module rotated_framebuffer_fill_engine #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd, x_start, y_start, x_end, y_end, run_length, rgb_color, zero pad
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_pixel, pixels_written
	output logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int HW  = $clog2(MAX_COLUMNS + 1);
	localparam int RHW = $clog2(MAX_ROWS + 1);

	logic [8:0]            cols_q;
	logic [7:0]            rows_q;
	logic [HW-1:0]         eff_cols;
	logic [RHW-1:0]        eff_rows;
	rfe_pkg::ctrl_cmd_t    cmd;
	rfe_pkg::ctrl_status_t status;
	rfe_pkg::out_item_t    out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 9'd256;
			rows_q <= 8'd128;
		end else if (cfg_we) begin
			case (cfg_index)
				rfe_pkg::REG_COLUMNS: cols_q <= cfg_data;
				rfe_pkg::REG_ROWS:    rows_q <= cfg_data[7:0];
				default:              cols_q <= cols_q;
			endcase
		end
	end

	// zero reads as one, large values saturate at the store size
	assign eff_cols = (cols_q == 9'd0) ? HW'(1) :
		((32'(cols_q) > MAX_COLUMNS) ? HW'(MAX_COLUMNS) : HW'(cols_q));
	assign eff_rows = (rows_q == 8'd0) ? RHW'(1) :
		((32'(rows_q) > MAX_ROWS) ? RHW'(MAX_ROWS) : RHW'(rows_q));

	rfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	rfe_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (rfe_pkg::in_item_t'(s_tdata)),
		.eff_cols (eff_cols),
		.eff_rows (eff_rows),
		.cmd      (cmd),
		.status   (status),
		.out_item (out_item)
	);

	assign m_tdata = out_item;

endmodule

@@ tb/sv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rfe_pkg::*;

	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 128;
	localparam int STORE_WORDS = MAX_COLUMNS * MAX_ROWS;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 185;

	// command codes the block treats as no-ops
	localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

	typedef struct {
		out_item_t   value;
		int unsigned seq;
		logic [2:0]  cmd;
	} outcome_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [8:0]  cfg_data  = '0;

	in_item_t    cmd_queue[$];
	outcome_t    expected_outcomes[$];
	logic [15:0] shadow_frame [STORE_WORDS];
	logic [8:0]  panel_cols_q = 9'd256;
	logic [7:0]  panel_rows_q = 8'd128;
	int unsigned writes_done;
	int unsigned accepted_count = 0;
	int unsigned mismatches = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          ready_mode = 0;
	int          mode_left = 0;

	always #6 clk = ~clk;

	rotated_framebuffer_fill_engine #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// logical width is the physical row count, logical height the column count
	function automatic int logical_width();
		int r;
		r = panel_rows_q;
		if (r == 0) r = 1;
		if (r > MAX_ROWS) r = MAX_ROWS;
		return r;
	endfunction

	function automatic int logical_height();
		int c;
		c = panel_cols_q;
		if (c == 0) c = 1;
		if (c > MAX_COLUMNS) c = MAX_COLUMNS;
		return c;
	endfunction

	function automatic int word_index(int x, int y);
		int a;
		a = (logical_width() - 1 - x) * logical_height() + y;
		if (a < 0 || a >= STORE_WORDS) a = 0;
		return a;
	endfunction

	function automatic void plot(int x, int y, logic [15:0] px);
		shadow_frame[word_index(x, y)] = px;
		writes_done++;
	endfunction

	function automatic void draw_run(int x, int y, bit horiz, int len, logic [15:0] px);
		int w, h, stop, i;
		w = logical_width();
		h = logical_height();
		if (x > w - 1) x = w - 1;
		if (y > h - 1) y = h - 1;
		if (len <= 0) return;
		if (horiz) begin
			stop = x + len - 1;
			if (stop > w - 1) stop = w - 1;
			for (i = x; i <= stop; i++) plot(i, y, px);
		end else begin
			stop = y + len - 1;
			if (stop > h - 1) stop = h - 1;
			for (i = y; i <= stop; i++) plot(x, i, px);
		end
	endfunction

	// apply one accepted command to the shadow frame and queue its outcome
	function automatic void render_command(in_item_t c);
		int xs, ys, xe, ye, w, h, x, y;
		logic [15:0] px;
		outcome_t o;
		xs = int'(c.x_start);
		ys = int'(c.y_start);
		xe = int'(c.x_end);
		ye = int'(c.y_end);
		w = logical_width();
		h = logical_height();
		px = {c.rgb_color[23:19], c.rgb_color[15:10], c.rgb_color[7:3]};
		o.value.read_pixel = '0;
		writes_done = 0;
		case (c.cmd)
			CMD_POINT: draw_run(xs, ys, 1'b1, 1, px);
			CMD_HLINE: draw_run(xs, ys, 1'b1, int'(c.run_length), px);
			CMD_VLINE: draw_run(xs, ys, 1'b0, int'(c.run_length), px);
			CMD_OUTLINE: begin
				// side lengths come from the raw corners, each side clamps on its own
				draw_run(xs, ys, 1'b1, xe - xs + 1, px);
				draw_run(xs, ye, 1'b1, xe - xs + 1, px);
				draw_run(xs, ys + 1, 1'b0, ye - ys - 1, px);
				draw_run(xe, ys + 1, 1'b0, ye - ys - 1, px);
			end
			CMD_FILL: begin
				if (xe > w - 1) xe = w - 1;
				if (ye > h - 1) ye = h - 1;
				for (y = ys; y <= ye; y++)
					for (x = xs; x <= xe; x++)
						plot(x, y, px);
			end
			CMD_READ: begin
				if (xs > w - 1) xs = w - 1;
				if (ys > h - 1) ys = h - 1;
				o.value.read_pixel = shadow_frame[word_index(xs, ys)];
			end
			default: ;
		endcase
		o.value.pixels_written = 16'(writes_done);
		o.seq = accepted_count;
		o.cmd = c.cmd;
		accepted_count++;
		expected_outcomes.push_back(o);
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < 40) $display("mismatch: %s", msg);
		mismatches++;
	endtask

	task automatic check_result(out_item_t got);
		outcome_t want;
		if (expected_outcomes.size() == 0) begin
			report_mismatch($sformatf("result %h with no command pending", got));
			return;
		end
		want = expected_outcomes.pop_front();
		if (got.read_pixel !== want.value.read_pixel)
			report_mismatch($sformatf("cmd #%0d (code %0d) read_pixel %h, want %h",
				want.seq, want.cmd, got.read_pixel, want.value.read_pixel));
		if (got.pixels_written !== want.value.pixels_written)
			report_mismatch($sformatf("cmd #%0d (code %0d) pixels_written %0d, want %0d",
				want.seq, want.cmd, got.pixels_written, want.value.pixels_written));
	endtask

	// command driver: bursts of beats separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) render_command(in_item_t'(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() != 0) begin
					s_tdata  <= cmd_queue.pop_front();
					s_tvalid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 20);
						if ($urandom_range(0, 3) == 0) gap_left = 0;
						else gap_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor; ready follows modes of random length
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) check_result(out_item_t'(m_tdata));
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 80);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				0, 1: m_tready <= 1'b1;
				2: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	task automatic queue_cmd(logic [2:0] cmd, int xs, int ys, int xe, int ye, int len,
			logic [23:0] rgb);
		in_item_t c;
		c = '0;
		c.cmd = cmd;
		c.x_start = 10'(xs);
		c.y_start = 10'(ys);
		c.x_end = 10'(xe);
		c.y_end = 10'(ye);
		c.run_length = 10'(len);
		c.rgb_color = rgb;
		cmd_queue.push_back(c);
	endtask

	function automatic logic [9:0] pick_coord(int lim);
		int v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 1023);
			1: v = lim - 1;
			2: v = lim - 1 + int'($urandom_range(0, 3));
			3: v = 0;
			default: v = $urandom_range(0, lim - 1);
		endcase
		return 10'(v);
	endfunction

	// far corner: mostly a small box, sometimes reversed, flat or anywhere
	function automatic logic [9:0] pick_far(int from, int lim);
		int v;
		case ($urandom_range(0, 31))
			0: v = $urandom_range(0, 1023);
			1, 2: v = from - int'($urandom_range(1, 3));
			3: v = from + 1;
			default: v = from + int'($urandom_range(0, (lim < 16) ? lim : 16));
		endcase
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return 10'(v);
	endfunction

	function automatic in_item_t random_command(int w, int h);
		in_item_t c;
		int roll;
		c = '0;
		roll = $urandom_range(0, 99);
		if (roll < 28) c.cmd = CMD_READ;
		else if (roll < 38) c.cmd = CMD_POINT;
		else if (roll < 50) c.cmd = CMD_HLINE;
		else if (roll < 62) c.cmd = CMD_VLINE;
		else if (roll < 76) c.cmd = CMD_OUTLINE;
		else if (roll < 96) c.cmd = CMD_FILL;
		else if (roll < 98) c.cmd = CMD_UNUSED_6;
		else c.cmd = CMD_UNUSED_7;
		c.x_start = pick_coord(w);
		c.y_start = pick_coord(h);
		c.x_end = pick_far(int'(c.x_start), w);
		c.y_end = pick_far(int'(c.y_start), h);
		case ($urandom_range(0, 7))
			0: c.run_length = 10'($urandom_range(0, 1023));
			1: c.run_length = '0;
			default: c.run_length = 10'($urandom_range(1, ((c.cmd == CMD_VLINE) ? h : w) + 1));
		endcase
		c.rgb_color = 24'($urandom());
		return c;
	endfunction

	task automatic set_panel(logic [8:0] cols, logic [8:0] rows);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_COLUMNS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_index <= REG_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_we <= 1'b0;
		panel_cols_q = cols;
		panel_rows_q = rows[7:0];
	endtask

	// sampled at the falling edge so all rising-edge updates have settled
	task automatic wait_idle();
		do @(negedge clk);
		while (cmd_queue.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int p, n;
		for (n = 0; n < STORE_WORDS; n++) shadow_frame[n] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		queue_cmd(CMD_POINT, 0, 0, 0, 0, 0, 24'hFFFFFF);
		queue_cmd(CMD_POINT, 1023, 1023, 1023, 1023, 1023, 24'hA5A5A5);
		queue_cmd(CMD_READ, 0, 0, 0, 0, 0, 24'h000000);
		queue_cmd(CMD_READ, 1023, 1023, 0, 0, 0, 24'h000000);
		queue_cmd(CMD_HLINE, 0, 5, 0, 0, 0, 24'h00FF00);
		queue_cmd(CMD_HLINE, 120, 5, 0, 0, 1023, 24'hFF0000);
		queue_cmd(CMD_VLINE, 3, 250, 0, 0, 1023, 24'h0000FF);
		queue_cmd(CMD_VLINE, 1023, 0, 0, 0, 1, 24'h808080);
		queue_cmd(CMD_OUTLINE, 10, 10, 20, 11, 0, 24'h112233);
		queue_cmd(CMD_OUTLINE, 10, 20, 20, 30, 0, 24'h445566);
		queue_cmd(CMD_OUTLINE, 30, 40, 25, 50, 0, 24'h778899);
		queue_cmd(CMD_OUTLINE, 40, 40, 40, 45, 0, 24'hAABBCC);
		queue_cmd(CMD_OUTLINE, 60, 70, 66, 70, 0, 24'hDDEEFF);
		queue_cmd(CMD_OUTLINE, 100, 200, 1023, 1023, 0, 24'h0F0F0F);
		queue_cmd(CMD_FILL, 5, 5, 8, 9, 0, 24'hF0F0F0);
		queue_cmd(CMD_FILL, 50, 50, 40, 60, 0, 24'h123123);
		queue_cmd(CMD_FILL, 0, 300, 5, 1023, 0, 24'h321321);
		queue_cmd(CMD_FILL, 1023, 0, 1023, 3, 0, 24'h555555);
		queue_cmd(CMD_READ, 6, 7, 0, 0, 0, 24'h000000);
		queue_cmd(CMD_READ, 40, 42, 0, 0, 0, 24'h000000);
		queue_cmd(CMD_UNUSED_6, 1023, 1023, 1023, 1023, 1023, 24'hFFFFFF);
		queue_cmd(CMD_UNUSED_7, 1, 1, 1, 1, 1, 24'h000001);
		queue_cmd(CMD_FILL, 0, 0, 1023, 1023, 0, 24'h123456);
		queue_cmd(CMD_HLINE, 512, 3, 0, 0, 2, 24'h00FFFF);
		queue_cmd(CMD_READ, 127, 3, 0, 0, 0, 24'h000000);

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: ;
				1: set_panel(9'd0, 9'd0);
				2: set_panel(9'h1FF, 9'h1FF);
				3: set_panel(9'd1, 9'd1);
				4: set_panel(9'd256, 9'd128);
				5: set_panel(9'd2, 9'd3);
				6: set_panel(9'd257, 9'd129);
				default: set_panel(9'($urandom_range(1, 40)), 9'($urandom_range(1, 24)));
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				cmd_queue.push_back(random_command(logical_width(), logical_height()));
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_outcomes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
